>>> rtl/ratacc_pkg.sv
// ----------------------------------------------------------------------------
// ratacc_pkg: shared definitions for the rational accumulator
// Word width default, port width and request codes used across the block.
// ----------------------------------------------------------------------------
package ratacc_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int PORT_BITS         = 32;

   typedef logic [2:0] req_kind_type;

   localparam req_kind_type REQ_LOAD = 3'd0;
   localparam req_kind_type REQ_ADD  = 3'd1;
   localparam req_kind_type REQ_INC  = 3'd2;
   localparam req_kind_type REQ_DEC  = 3'd3;
   localparam req_kind_type REQ_CMP  = 3'd4;

endpackage

>>> rtl/ratacc_divider.sv
// ----------------------------------------------------------------------------
// ratacc_divider: shared signed divide unit
// Restoring divider, one quotient bit per cycle. Quotient and remainder follow
// truncating division; the most negative value over minus one wraps.
// ----------------------------------------------------------------------------
module ratacc_divider #(
   parameter int WORD_BITS = ratacc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic                 done,
   output logic [WORD_BITS-1:0] quotient,
   output logic [WORD_BITS-1:0] remainder
);

   localparam int CntBits = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] dmag_ff, dmag_in;
   logic                 qneg_ff, qneg_in;
   logic                 rneg_ff, rneg_in;

   logic [WORD_BITS:0]   shifted;
   logic [WORD_BITS:0]   diff;

   assign shifted = {rem_ff, quo_ff[WORD_BITS-1]};
   assign diff    = shifted - {1'b0, dmag_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = CntBits'(WORD_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
         dmag_in = divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
         qneg_in = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
         rneg_in = dividend[WORD_BITS-1];
      end else if (run_ff) begin
         // A non-negative trial difference means the divisor fits.
         if (!diff[WORD_BITS]) begin
            rem_in = diff[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign remainder = rneg_ff ? (~rem_ff + 1'b1) : rem_ff;

endmodule

>>> rtl/rational_accumulator.sv
// ----------------------------------------------------------------------------
// rational_accumulator: stored rational value with load, add, increment,
// decrement and compare. Keeps one signed numerator/denominator pair reduced by a Euclid GCD.
// ----------------------------------------------------------------------------
// Usage: drive req_type and the operand ports and raise start while busy is
// low; the request transfers on that clock edge and busy is high from then on.
// Exactly one result appears per request: rsp_valid is high for one cycle
// with before and after values and the flags, and busy drops in that cycle.
// The receiver cannot stall the block; results must be taken when shown.
// Steps: increment, compare and unused codes go straight to the finishing
// state. Load and decrement run Euclid remainder steps on the shared
// restoring divider, one quotient bit per cycle, then divide numerator and
// denominator by the GCD; a value of zero over zero skips the divisions.
// Add first forms its three products on the shared multiplier. One request
// is in work at a time, and the next one can transfer at the edge that takes
// the result.
// Reset (synchronous) sets the value to 0/1 and aborts any request in work.
// ----------------------------------------------------------------------------
module rational_accumulator #(
   parameter int WORD_BITS = ratacc_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [2:0]                               req_type,
   input  logic signed [ratacc_pkg::PORT_BITS-1:0]  req_operand_num,
   input  logic signed [ratacc_pkg::PORT_BITS-1:0]  req_operand_den,
   output logic                                     rsp_valid,
   output logic signed [ratacc_pkg::PORT_BITS-1:0]  rsp_before_num,
   output logic signed [ratacc_pkg::PORT_BITS-1:0]  rsp_before_den,
   output logic signed [ratacc_pkg::PORT_BITS-1:0]  rsp_after_num,
   output logic signed [ratacc_pkg::PORT_BITS-1:0]  rsp_after_den,
   output logic                                     rsp_nonzero,
   output logic                                     rsp_equal,
   output logic                                     rsp_div_error
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_MUL_A      = 4'd1;
   localparam logic [3:0] S_MUL_B      = 4'd2;
   localparam logic [3:0] S_MUL_C      = 4'd3;
   localparam logic [3:0] S_MUL_D      = 4'd4;
   localparam logic [3:0] S_GCD_CHECK  = 4'd5;
   localparam logic [3:0] S_GCD_WAIT   = 4'd6;
   localparam logic [3:0] S_DIVN_START = 4'd7;
   localparam logic [3:0] S_DIVN_WAIT  = 4'd8;
   localparam logic [3:0] S_DIVD_START = 4'd9;
   localparam logic [3:0] S_DIVD_WAIT  = 4'd10;
   localparam logic [3:0] S_FINISH     = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] num_ff, num_in;
   logic [WORD_BITS-1:0] den_ff, den_in;
   logic [WORD_BITS-1:0] bnum_ff, bnum_in;
   logic [WORD_BITS-1:0] bden_ff, bden_in;
   logic [WORD_BITS-1:0] opn_ff, opn_in;
   logic [WORD_BITS-1:0] opd_ff, opd_in;
   logic [WORD_BITS-1:0] tn_ff, tn_in;
   logic [WORD_BITS-1:0] td_ff, td_in;
   logic [WORD_BITS-1:0] gx_ff, gx_in;
   logic [WORD_BITS-1:0] gy_ff, gy_in;
   logic [WORD_BITS-1:0] prod_ff, prod_in;
   logic                 eq_ff, eq_in;
   logic                 err_ff, err_in;

   logic [WORD_BITS-1:0] req_num;
   logic [WORD_BITS-1:0] req_den;
   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   logic [WORD_BITS-1:0] mul_p;
   logic                 div_start;
   logic [WORD_BITS-1:0] div_dividend;
   logic [WORD_BITS-1:0] div_divisor;
   logic                 div_done;
   logic [WORD_BITS-1:0] div_quot;
   logic [WORD_BITS-1:0] div_rem;

   logic signed [WORD_BITS-1:0] bnum_s;
   logic signed [WORD_BITS-1:0] bden_s;
   logic signed [WORD_BITS-1:0] num_s;
   logic signed [WORD_BITS-1:0] den_s;

   assign req_num = WORD_BITS'(req_operand_num);
   assign req_den = WORD_BITS'(req_operand_den);

   // Shared multiplier; only the low word of each product is kept.
   always_comb begin
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = bnum_ff;
            mul_b = opd_ff;
         end
         S_MUL_B: begin
            mul_a = opn_ff;
            mul_b = bden_ff;
         end
         default: begin
            mul_a = bden_ff;
            mul_b = opd_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      unique case (state_ff)
         S_DIVN_START: begin
            div_dividend = tn_ff;
            div_divisor  = gx_ff;
         end
         S_DIVD_START: begin
            div_dividend = td_ff;
            div_divisor  = gx_ff;
         end
         default: begin
            div_dividend = gx_ff;
            div_divisor  = gy_ff;
         end
      endcase
   end

   assign div_start = ((state_ff == S_GCD_CHECK) && (gy_ff != '0)) ||
                      (state_ff == S_DIVN_START) || (state_ff == S_DIVD_START);

   ratacc_divider #(
      .WORD_BITS (WORD_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      num_in       = num_ff;
      den_in       = den_ff;
      bnum_in      = bnum_ff;
      bden_in      = bden_ff;
      opn_in       = opn_ff;
      opd_in       = opd_ff;
      tn_in        = tn_ff;
      td_in        = td_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      prod_in      = prod_ff;
      eq_in        = eq_ff;
      err_in       = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               bnum_in = num_ff;
               bden_in = den_ff;
               opn_in  = req_num;
               opd_in  = req_den;
               eq_in   = 1'b0;
               err_in  = 1'b0;
               tn_in   = num_ff;
               td_in   = den_ff;
               state_in = S_FINISH;
               unique case (req_type)
                  ratacc_pkg::REQ_LOAD: begin
                     tn_in    = req_num;
                     td_in    = req_den;
                     gx_in    = req_num;
                     gy_in    = req_den;
                     state_in = S_GCD_CHECK;
                  end
                  ratacc_pkg::REQ_ADD: begin
                     state_in = S_MUL_A;
                  end
                  ratacc_pkg::REQ_INC: begin
                     tn_in = num_ff + den_ff;
                  end
                  ratacc_pkg::REQ_DEC: begin
                     tn_in    = num_ff - den_ff;
                     gx_in    = num_ff - den_ff;
                     gy_in    = den_ff;
                     state_in = S_GCD_CHECK;
                  end
                  ratacc_pkg::REQ_CMP: begin
                     eq_in = (num_ff == req_num) && (den_ff == req_den);
                  end
                  default: begin
                     // Unused codes leave the value as it is.
                  end
               endcase
            end
         end
         S_MUL_A: begin
            prod_in  = mul_p;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            tn_in    = prod_ff;
            prod_in  = mul_p;
            state_in = S_MUL_C;
         end
         S_MUL_C: begin
            tn_in    = tn_ff + prod_ff;
            prod_in  = mul_p;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            td_in    = prod_ff;
            gx_in    = tn_ff;
            gy_in    = prod_ff;
            state_in = S_GCD_CHECK;
         end
         S_GCD_CHECK: begin
            if (gy_ff == '0) begin
               // A zero GCD only arises when both fields are zero.
               if (gx_ff == '0) begin
                  err_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_DIVN_START;
               end
            end else begin
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               gx_in    = gy_ff;
               gy_in    = div_rem;
               state_in = S_GCD_CHECK;
            end
         end
         S_DIVN_START: begin
            state_in = S_DIVN_WAIT;
         end
         S_DIVN_WAIT: begin
            if (div_done) begin
               tn_in    = div_quot;
               state_in = S_DIVD_START;
            end
         end
         S_DIVD_START: begin
            state_in = S_DIVD_WAIT;
         end
         S_DIVD_WAIT: begin
            if (div_done) begin
               td_in    = div_quot;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            num_in       = tn_ff;
            den_in       = td_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         num_ff       <= '0;
         den_ff       <= WORD_BITS'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
      end
      bnum_ff <= bnum_in;
      bden_ff <= bden_in;
      opn_ff  <= opn_in;
      opd_ff  <= opd_in;
      tn_ff   <= tn_in;
      td_ff   <= td_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      prod_ff <= prod_in;
      eq_ff   <= eq_in;
      err_ff  <= err_in;
   end

   assign bnum_s = bnum_ff;
   assign bden_s = bden_ff;
   assign num_s  = num_ff;
   assign den_s  = den_ff;

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_before_num = ratacc_pkg::PORT_BITS'(bnum_s);
   assign rsp_before_den = ratacc_pkg::PORT_BITS'(bden_s);
   assign rsp_after_num  = ratacc_pkg::PORT_BITS'(num_s);
   assign rsp_after_den  = ratacc_pkg::PORT_BITS'(den_s);
   assign rsp_nonzero    = (num_ff != '0);
   assign rsp_equal      = eq_ff;
   assign rsp_div_error  = err_ff;

`ifndef ASSERT_OFF
   a_rsp_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a request is still in work");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (num_ff == '0) && (den_ff == '0))
      else $error("zero GCD reported for a value that is not zero over zero");

   a_equal_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_equal) |->
         (num_ff == bnum_ff) && (den_ff == bden_ff) && !rsp_div_error)
      else $error("compare changed the stored value");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_GCD_WAIT) || (state_ff == S_DIVN_WAIT) ||
                   (state_ff == S_DIVD_WAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule

>>> sim/rational_accumulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_accumulator_tb: self-checking bench for the rational accumulator
// Sends load, add, increment, decrement, compare and unused requests with
// random gaps or none, predicts every result from a local copy of the stored ratio
// and compares each returned result field by field.
// ----------------------------------------------------------------------------
module rational_accumulator_tb;

   localparam int WORD_WIDTH = ratacc_pkg::WORD_BITS_DEFAULT;

   // Request codes that the block leaves without effect.
   localparam ratacc_pkg::req_kind_type REQ_UNUSED_FIRST = 3'd5;
   localparam ratacc_pkg::req_kind_type REQ_UNUSED_LAST  = 3'd7;

   localparam logic [ratacc_pkg::PORT_BITS-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [ratacc_pkg::PORT_BITS-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [ratacc_pkg::PORT_BITS-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;
   // Consecutive Fibonacci numbers give the longest Euclid chains.
   localparam logic [ratacc_pkg::PORT_BITS-1:0] FIB_46 = 32'd1836311903;
   localparam logic [ratacc_pkg::PORT_BITS-1:0] FIB_45 = 32'd1134903170;
   localparam logic [ratacc_pkg::PORT_BITS-1:0] FIB_44 = 32'd701408733;

   typedef struct packed {
      logic signed [ratacc_pkg::PORT_BITS-1:0] before_num;
      logic signed [ratacc_pkg::PORT_BITS-1:0] before_den;
      logic signed [ratacc_pkg::PORT_BITS-1:0] after_num;
      logic signed [ratacc_pkg::PORT_BITS-1:0] after_den;
      logic                                    nonzero;
      logic                                    equal;
      logic                                    div_error;
   } ratio_result_type;

   logic                                    clock = 1'b0;
   logic                                    reset;
   logic                                    start;
   logic                                    busy;
   logic [2:0]                              req_type;
   logic signed [ratacc_pkg::PORT_BITS-1:0] req_operand_num;
   logic signed [ratacc_pkg::PORT_BITS-1:0] req_operand_den;
   logic                                    rsp_valid;
   logic signed [ratacc_pkg::PORT_BITS-1:0] rsp_before_num;
   logic signed [ratacc_pkg::PORT_BITS-1:0] rsp_before_den;
   logic signed [ratacc_pkg::PORT_BITS-1:0] rsp_after_num;
   logic signed [ratacc_pkg::PORT_BITS-1:0] rsp_after_den;
   logic                                    rsp_nonzero;
   logic                                    rsp_equal;
   logic                                    rsp_div_error;

   // Local copy of the stored ratio, kept as sign-extended word values.
   longint           acc_num;
   longint           acc_den;
   ratio_result_type pending_ratios[$];
   bit               send_gapless;
   int               mismatch_count;
   int               results_checked;
   int               zero_gcd_seen;
   int               equal_seen;
   int               kind_count[8];

   rational_accumulator #(.WORD_BITS(WORD_WIDTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_operand_num (req_operand_num),
      .req_operand_den (req_operand_den),
      .rsp_valid       (rsp_valid),
      .rsp_before_num  (rsp_before_num),
      .rsp_before_den  (rsp_before_den),
      .rsp_after_num   (rsp_after_num),
      .rsp_after_den   (rsp_after_den),
      .rsp_nonzero     (rsp_nonzero),
      .rsp_equal       (rsp_equal),
      .rsp_div_error   (rsp_div_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Keeps the low WORD_WIDTH bits and sign extends them.
   function automatic longint fit_word(longint v);
      logic [63:0] t;
      t = 64'(v) << (64 - WORD_WIDTH);
      return $signed(t) >>> (64 - WORD_WIDTH);
   endfunction

   // Euclid with truncating remainder, so the sign follows the operands.
   function automatic longint trunc_gcd(longint x, longint y);
      longint r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic bit reduce_acc();
      longint g;
      g = trunc_gcd(acc_num, acc_den);
      if (g == 0) begin
         return 1'b1;
      end
      acc_num = fit_word(acc_num / g);
      acc_den = fit_word(acc_den / g);
      return 1'b0;
   endfunction

   function automatic ratio_result_type predict_ratio(
         ratacc_pkg::req_kind_type kind,
         logic signed [ratacc_pkg::PORT_BITS-1:0] num,
         logic signed [ratacc_pkg::PORT_BITS-1:0] den);
      ratio_result_type r;
      longint           on;
      longint           od;
      longint           bn;
      longint           bd;
      bit               err;
      bit               eq;
      on  = fit_word(longint'(num));
      od  = fit_word(longint'(den));
      bn  = acc_num;
      bd  = acc_den;
      err = 1'b0;
      eq  = 1'b0;
      case (kind)
         ratacc_pkg::REQ_LOAD: begin
            acc_num = on;
            acc_den = od;
            err = reduce_acc();
         end
         ratacc_pkg::REQ_ADD: begin
            acc_num = fit_word(fit_word(bn * od) + fit_word(on * bd));
            acc_den = fit_word(bd * od);
            err = reduce_acc();
         end
         ratacc_pkg::REQ_INC: acc_num = fit_word(bn + bd);
         ratacc_pkg::REQ_DEC: begin
            acc_num = fit_word(bn - bd);
            err = reduce_acc();
         end
         ratacc_pkg::REQ_CMP: eq = (bn == on) && (bd == od);
         default: ;
      endcase
      r.before_num = bn[ratacc_pkg::PORT_BITS-1:0];
      r.before_den = bd[ratacc_pkg::PORT_BITS-1:0];
      r.after_num  = acc_num[ratacc_pkg::PORT_BITS-1:0];
      r.after_den  = acc_den[ratacc_pkg::PORT_BITS-1:0];
      r.nonzero    = (acc_num != 0);
      r.equal      = eq;
      r.div_error  = err;
      return r;
   endfunction

   function automatic logic [ratacc_pkg::PORT_BITS-1:0] pick_operand();
      logic [ratacc_pkg::PORT_BITS-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return ratacc_pkg::PORT_BITS'(int'($urandom_range(0, 16)) - 8);
         1: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return 32'd1;
               2: return WORD_NEG_ONE;
               3: return WORD_MIN;
               default: return WORD_MAX;
            endcase
         end
         2: return {{16{r[15]}}, r[15:0]};
         default: return r;
      endcase
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      $display("%0t ns: result %0d, %s is %0d, expected %0d",
               $time, results_checked, what, got, want);
   endtask

   // One request transfer; the expectation is taken at the accepting edge.
   task automatic transfer_request(ratacc_pkg::req_kind_type kind,
                                   logic [ratacc_pkg::PORT_BITS-1:0] num,
                                   logic [ratacc_pkg::PORT_BITS-1:0] den);
      int gap;
      gap = send_gapless ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_type        <= kind;
      req_operand_num <= num;
      req_operand_den <= den;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_ratios.push_back(predict_ratio(kind, num, den));
      kind_count[kind]++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_ratios.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      ratio_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_ratios.size() == 0) begin
            report_mismatch("unexpected result, after_num", rsp_after_num, 0);
         end else begin
            want = pending_ratios.pop_front();
            if (rsp_before_num !== want.before_num)
               report_mismatch("before_num", rsp_before_num, want.before_num);
            if (rsp_before_den !== want.before_den)
               report_mismatch("before_den", rsp_before_den, want.before_den);
            if (rsp_after_num !== want.after_num)
               report_mismatch("after_num", rsp_after_num, want.after_num);
            if (rsp_after_den !== want.after_den)
               report_mismatch("after_den", rsp_after_den, want.after_den);
            if (rsp_nonzero !== want.nonzero)
               report_mismatch("nonzero", rsp_nonzero, want.nonzero);
            if (rsp_equal !== want.equal)
               report_mismatch("equal", rsp_equal, want.equal);
            if (rsp_div_error !== want.div_error)
               report_mismatch("div_error", rsp_div_error, want.div_error);
            if (want.div_error) zero_gcd_seen++;
            if (want.equal) equal_seen++;
            results_checked++;
         end
      end
   end

   // The value after reset is 0/1; compare it, then walk it through increment and decrement.
   task automatic test_reset_state();
      transfer_request(ratacc_pkg::REQ_CMP, '0, 32'd1);
      transfer_request(ratacc_pkg::REQ_INC, WORD_MAX, WORD_MIN);
      transfer_request(ratacc_pkg::REQ_DEC, '0, '0);
      transfer_request(ratacc_pkg::REQ_DEC, WORD_NEG_ONE, WORD_NEG_ONE);
   endtask

   // Extreme word values; most negative over minus one wraps back to the most negative value.
   task automatic test_extremes();
      transfer_request(ratacc_pkg::REQ_LOAD, WORD_MAX, WORD_MIN);
      transfer_request(ratacc_pkg::REQ_ADD, WORD_MIN, WORD_MAX);
      transfer_request(ratacc_pkg::REQ_LOAD, WORD_MIN, WORD_NEG_ONE);
      transfer_request(ratacc_pkg::REQ_LOAD, WORD_NEG_ONE, WORD_MIN);
      transfer_request(ratacc_pkg::REQ_LOAD, WORD_MAX, 32'd1);
      transfer_request(ratacc_pkg::REQ_INC, '0, '0);
   endtask

   // Both fields zero give a zero GCD; a zero denominator alone does not.
   task automatic test_zero_gcd();
      transfer_request(ratacc_pkg::REQ_LOAD, '0, '0);
      transfer_request(ratacc_pkg::REQ_ADD, 32'd3, 32'd4);
      transfer_request(ratacc_pkg::REQ_INC, '0, '0);
      transfer_request(ratacc_pkg::REQ_LOAD, 32'd7, '0);
      transfer_request(ratacc_pkg::REQ_ADD, 32'd1, '0);
   endtask

   task automatic test_sign_rules();
      transfer_request(ratacc_pkg::REQ_LOAD, 32'd6, -32'sd4);
      transfer_request(ratacc_pkg::REQ_LOAD, -32'sd6, 32'd4);
   endtask

   task automatic test_deep_euclid();
      transfer_request(ratacc_pkg::REQ_LOAD, FIB_46, FIB_45);
      transfer_request(ratacc_pkg::REQ_ADD, FIB_45, FIB_44);
   endtask

   task automatic test_compare_and_unused();
      ratacc_pkg::req_kind_type code;
      transfer_request(ratacc_pkg::REQ_CMP, acc_num[ratacc_pkg::PORT_BITS-1:0],
                       acc_den[ratacc_pkg::PORT_BITS-1:0]);
      transfer_request(ratacc_pkg::REQ_CMP, WORD_MAX, WORD_MIN);
      for (code = REQ_UNUSED_FIRST; code <= REQ_UNUSED_LAST; code++) begin
         transfer_request(code, WORD_NEG_ONE, WORD_NEG_ONE);
         if (code == REQ_UNUSED_LAST) break;
      end
   endtask

   task automatic test_random_mix(int count);
      int                       pick;
      ratacc_pkg::req_kind_type kind;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) send_gapless = !send_gapless;
         pick = $urandom_range(0, 99);
         if (pick < 20)      kind = ratacc_pkg::REQ_LOAD;
         else if (pick < 45) kind = ratacc_pkg::REQ_ADD;
         else if (pick < 60) kind = ratacc_pkg::REQ_INC;
         else if (pick < 75) kind = ratacc_pkg::REQ_DEC;
         else if (pick < 95) kind = ratacc_pkg::REQ_CMP;
         else kind = ratacc_pkg::req_kind_type'(
                        $urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
         // Half of the compares use the current value so that equal is hit.
         if (kind == ratacc_pkg::REQ_CMP && $urandom_range(0, 1) == 1)
            transfer_request(kind, acc_num[ratacc_pkg::PORT_BITS-1:0],
                             acc_den[ratacc_pkg::PORT_BITS-1:0]);
         else
            transfer_request(kind, pick_operand(), pick_operand());
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = ratacc_pkg::REQ_LOAD;
      req_operand_num = '0;
      req_operand_den = '0;
      acc_num         = 0;
      acc_den         = 1;
      send_gapless    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_extremes();
      test_zero_gcd();
      test_sign_rules();
      send_gapless = 1'b1;
      test_deep_euclid();
      send_gapless = 1'b0;
      test_compare_and_unused();
      wait_for_results();
      test_random_mix(400);
      wait_for_results();
      send_gapless = 1'b1;
      test_random_mix(150);
      send_gapless = 1'b0;
      test_random_mix(450);
      wait_for_results();
      repeat (16) @(posedge clock);

      $display("Sent %0d loads, %0d adds, %0d increments, %0d decrements, %0d compares",
               kind_count[ratacc_pkg::REQ_LOAD], kind_count[ratacc_pkg::REQ_ADD],
               kind_count[ratacc_pkg::REQ_INC], kind_count[ratacc_pkg::REQ_DEC],
               kind_count[ratacc_pkg::REQ_CMP]);
      $display("and %0d unused codes; %0d results checked, %0d zero GCD, %0d equal.",
               kind_count[5] + kind_count[6] + kind_count[7], results_checked,
               zero_gcd_seen, equal_seen);
      if (mismatch_count == 0 && pending_ratios.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(64'd100_000_000);
      $display("Timed out with %0d results outstanding.", pending_ratios.size());
      $display("status: fail");
      $finish;
   end

endmodule

>>> rational_accumulator.f
rtl/ratacc_pkg.sv
rtl/ratacc_divider.sv
rtl/rational_accumulator.sv
sim/rational_accumulator_tb.sv
